// ===== sv/imhq_pkg.sv =====
// Shared types and constants for the indexed min-heap priority queue.
// Used by indexed_min_heap_queue_unit; depends on nothing else.
package imhq_pkg;

    localparam int unsigned DEF_CAPACITY = 256;
    localparam int unsigned DEF_NUM_IDS  = 256;
    localparam int unsigned DEF_KEY_BITS = 32;

    localparam int unsigned CFG_W   = 9;
    localparam int unsigned ITEM_W  = 8;
    localparam int unsigned FIELD_W = 32;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = 9'd256;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_UPDATE  = 2'd2,
        REQ_QUERY   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_PRESENT = 3'd4
    } status_t;

    typedef struct packed {
        req_t                      req_type;
        logic [ITEM_W-1:0]         item_id;
        logic signed [FIELD_W-1:0] key_value;
    } in_item_t;

    typedef struct packed {
        status_t                   status;
        logic                      min_valid;
        logic [ITEM_W-1:0]         min_id;
        logic signed [FIELD_W-1:0] min_value;
        logic [CFG_W-1:0]          entry_total;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_UP,
        S_UP_CMP,
        S_ROOT,
        S_LAST,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_WB,
        S_OUT
    } state_t;

endpackage

// ===== sv/indexed_min_heap_queue_unit.sv =====
// Top level of the indexed min-heap priority queue: heap memory, id table
// memory and the sequencer that sifts entries. Depends on imhq_pkg.
//
// Usage. Requests enter on the in channel (in_valid, in_stall, in_data) and
// each request gives exactly one result on the out channel (out_valid,
// out_stall, out_data). A transfer happens at a rising edge where valid is
// high and stall is low. The capacity register is written through the cfg
// channel (cfg_valid, cfg_ready, cfg_data); cfg_ready is always high.
//
// Operation. One request is worked on at a time. The heap and
// the id table are synchronous memories with one read port each, so every
// heap level costs a read and a compare: insert climbs level by level,
// update climbs and then descends, and extract descends level by level
// (up to 8 levels at a capacity of 256). Query and every error end
// without a sift.
//
// Reset. After rst_n rises the block sweeps the id table once, one entry a
// cycle, holding in_stall high; configuration writes are taken during
// that sweep. The heap memory itself is never cleared.
//
// Stalls. The result sits in an output register. If the receiver stalls,
// a finished request waits in its last state until the register frees up.
module indexed_min_heap_queue_unit
#(
    parameter int unsigned CAPACITY = imhq_pkg::DEF_CAPACITY,
    parameter int unsigned NUM_IDS  = imhq_pkg::DEF_NUM_IDS,
    parameter int unsigned KEY_BITS = imhq_pkg::DEF_KEY_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  imhq_pkg::in_item_t         in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output imhq_pkg::out_item_t        out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [imhq_pkg::CFG_W-1:0] cfg_data
);
    import imhq_pkg::*;

    localparam int unsigned SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
    localparam int unsigned ID_W   = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int unsigned CHILD_W = SLOT_W + 2;
    localparam int unsigned CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

    typedef struct packed {
        logic [ID_W-1:0]            id;
        logic signed [KEY_BITS-1:0] key;
    } heap_ent_t;

    typedef struct packed {
        logic              present;
        logic [SLOT_W-1:0] slot;
    } id_ent_t;

    // Memories: heap slots and the per-id table.
    heap_ent_t heap_mem [CAPACITY];
    id_ent_t   id_mem   [NUM_IDS];

    logic              hp_re, hp_we;
    logic [SLOT_W-1:0] hp_raddr, hp_waddr;
    heap_ent_t         hp_wdata, hp_rdata;
    logic              id_re, id_we;
    logic [ID_W-1:0]   id_raddr, id_waddr;
    id_ent_t           id_wdata, id_rdata;

    always_ff @(posedge clk)
    begin
        if (hp_we)
        begin
            heap_mem[hp_waddr] <= hp_wdata;
        end
        if (hp_re)
        begin
            hp_rdata <= heap_mem[hp_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[id_waddr] <= id_wdata;
        end
        if (id_re)
        begin
            id_rdata <= id_mem[id_raddr];
        end
    end

    // Control and working registers.
    state_t                     state_reg, state_next;
    logic [CFG_W-1:0]           cap_reg;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [ID_W-1:0]            clr_reg, clr_next;
    req_t                       req_reg, req_next;
    logic                       rng_reg, rng_next;
    logic [SLOT_W-1:0]          hole_reg, hole_next;
    logic [ID_W-1:0]            cur_id_reg, cur_id_next;
    logic signed [KEY_BITS-1:0] cur_key_reg, cur_key_next;
    heap_ent_t                  left_reg, left_next;
    status_t                    status_reg, status_next;
    logic                       minv_reg, minv_next;
    logic [ID_W-1:0]            mid_reg, mid_next;
    logic signed [KEY_BITS-1:0] mval_reg, mval_next;
    logic                       out_valid_reg, out_valid_next;
    out_item_t                  out_reg, out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cap_reg       <= CAPACITY_RESET;
            fill_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        rng_reg     <= rng_next;
        hole_reg    <= hole_next;
        cur_id_reg  <= cur_id_next;
        cur_key_reg <= cur_key_next;
        left_reg    <= left_next;
        status_reg  <= status_next;
        minv_reg    <= minv_next;
        mid_reg     <= mid_next;
        mval_reg    <= mval_next;
        out_reg     <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    logic [CMP_W-1:0]   eff_cap;
    logic [CHILD_W-1:0] lchild, rchild, fill_ext;
    logic [SLOT_W-1:0]  parent;
    logic               left_less, right_less;

    always_comb
    begin
        eff_cap = (CMP_W'(cap_reg) < CMP_W'(CAPACITY)) ? CMP_W'(cap_reg) : CMP_W'(CAPACITY);
        lchild   = {1'b0, hole_reg, 1'b1};
        rchild   = lchild + CHILD_W'(1);
        fill_ext = CHILD_W'(fill_reg);
        parent   = (hole_reg - SLOT_W'(1)) >> 1;
        // Left wins against the moving entry only when strictly smaller;
        // right must beat the smaller of the two.
        left_less  = left_reg.key < cur_key_reg;
        right_less = left_less ? (hp_rdata.key < left_reg.key)
                               : (hp_rdata.key < cur_key_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        clr_next       = clr_reg;
        req_next       = req_reg;
        rng_next       = rng_reg;
        hole_next      = hole_reg;
        cur_id_next    = cur_id_reg;
        cur_key_next   = cur_key_reg;
        left_next      = left_reg;
        status_next    = status_reg;
        minv_next      = minv_reg;
        mid_next       = mid_reg;
        mval_next      = mval_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        hp_re    = 1'b0;
        hp_raddr = '0;
        hp_we    = 1'b0;
        hp_waddr = hole_reg;
        hp_wdata = '{id: cur_id_reg, key: cur_key_reg};
        id_re    = 1'b0;
        id_raddr = '0;
        id_we    = 1'b0;
        id_waddr = cur_id_reg;
        id_wdata = '{present: 1'b1, slot: hole_reg};

        case (state_reg)
            S_CLEAR:
            begin
                id_we    = 1'b1;
                id_waddr = clr_reg;
                id_wdata = '0;
                clr_next = clr_reg + ID_W'(1);
                if (clr_reg == ID_W'(NUM_IDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next     = in_data.req_type;
                    rng_next     = {24'd0, in_data.item_id} < 32'(NUM_IDS);
                    cur_id_next  = ID_W'(in_data.item_id);
                    cur_key_next = KEY_BITS'(in_data.key_value);
                    status_next  = ST_OK;
                    minv_next    = 1'b0;
                    mid_next     = '0;
                    mval_next    = '0;
                    id_re        = 1'b1;
                    id_raddr     = ID_W'(in_data.item_id);
                    state_next   = S_CHECK;
                end
            end

            S_CHECK:
            begin
                case (req_reg)
                    REQ_INSERT:
                    begin
                        if (!rng_reg)
                        begin
                            status_next = ST_UNKNOWN;
                            state_next  = S_OUT;
                        end
                        else if (id_rdata.present)
                        begin
                            status_next = ST_PRESENT;
                            state_next  = S_OUT;
                        end
                        else if (CMP_W'(fill_reg) >= eff_cap)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            hole_next  = SLOT_W'(fill_reg);
                            fill_next  = fill_reg + FILL_W'(1);
                            state_next = S_UP;
                        end
                    end
                    REQ_UPDATE:
                    begin
                        if (!rng_reg || !id_rdata.present
                            || (FILL_W'(id_rdata.slot) >= fill_reg))
                        begin
                            status_next = ST_UNKNOWN;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            hole_next  = id_rdata.slot;
                            state_next = S_UP;
                        end
                    end
                    default:
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            hp_re      = 1'b1;
                            hp_raddr   = '0;
                            state_next = S_ROOT;
                        end
                    end
                endcase
            end

            S_UP:
            begin
                if (hole_reg == '0)
                begin
                    state_next = (req_reg == REQ_UPDATE) ? S_DN : S_WB;
                end
                else
                begin
                    hp_re      = 1'b1;
                    hp_raddr   = parent;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                if (cur_key_reg < hp_rdata.key)
                begin
                    // Parent moves down into the hole.
                    hp_we      = 1'b1;
                    hp_wdata   = hp_rdata;
                    id_we      = 1'b1;
                    id_waddr   = hp_rdata.id;
                    hole_next  = parent;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = (req_reg == REQ_UPDATE) ? S_DN : S_WB;
                end
            end

            S_ROOT:
            begin
                minv_next = 1'b1;
                mid_next  = hp_rdata.id;
                mval_next = hp_rdata.key;
                if (req_reg == REQ_QUERY)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    hp_re      = 1'b1;
                    hp_raddr   = SLOT_W'(fill_reg - FILL_W'(1));
                    state_next = S_LAST;
                end
            end

            S_LAST:
            begin
                cur_id_next  = hp_rdata.id;
                cur_key_next = hp_rdata.key;
                fill_next    = fill_reg - FILL_W'(1);
                id_we        = 1'b1;
                id_waddr     = mid_reg;
                id_wdata     = '0;
                hole_next    = '0;
                // When the root was the only entry nothing moves back.
                state_next   = (fill_reg == FILL_W'(1)) ? S_OUT : S_DN;
            end

            S_DN:
            begin
                if (lchild >= fill_ext)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    hp_re      = 1'b1;
                    hp_raddr   = lchild[SLOT_W-1:0];
                    state_next = S_DN_L;
                end
            end

            S_DN_L:
            begin
                left_next = hp_rdata;
                if (rchild < fill_ext)
                begin
                    hp_re      = 1'b1;
                    hp_raddr   = rchild[SLOT_W-1:0];
                    state_next = S_DN_R;
                end
                else if (hp_rdata.key < cur_key_reg)
                begin
                    hp_we      = 1'b1;
                    hp_wdata   = hp_rdata;
                    id_we      = 1'b1;
                    id_waddr   = hp_rdata.id;
                    hole_next  = lchild[SLOT_W-1:0];
                    state_next = S_DN;
                end
                else
                begin
                    state_next = S_WB;
                end
            end

            S_DN_R:
            begin
                if (right_less)
                begin
                    hp_we      = 1'b1;
                    hp_wdata   = hp_rdata;
                    id_we      = 1'b1;
                    id_waddr   = hp_rdata.id;
                    hole_next  = rchild[SLOT_W-1:0];
                    state_next = S_DN;
                end
                else if (left_less)
                begin
                    hp_we      = 1'b1;
                    hp_wdata   = left_reg;
                    id_we      = 1'b1;
                    id_waddr   = left_reg.id;
                    hole_next  = lchild[SLOT_W-1:0];
                    state_next = S_DN;
                end
                else
                begin
                    state_next = S_WB;
                end
            end

            S_WB:
            begin
                // The moving entry lands in the final hole.
                hp_we      = 1'b1;
                id_we      = 1'b1;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = status_reg;
                    out_next.min_valid    = minv_reg;
                    out_next.min_id       = ITEM_W'(mid_reg);
                    out_next.min_value    = FIELD_W'(mval_reg);
                    out_next.entry_total  = CFG_W'(fill_reg);
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
